// ===== src/tcw_pkg.sv =====
// Shared types and constants for the text console writer.
// Used by tcw_cursor and text_console_writer; no dependencies.
package tcw_pkg;

	// Default screen geometry and tab spacing.
	localparam int COLUMNS_DEF  = 80;
	localparam int ROWS_DEF     = 25;
	localparam int TAB_STOP_DEF = 4;

	// Width of the position fields on the stream ports.
	localparam int FIELD_W = 11;

	// Character codes with special handling.
	localparam logic [7:0] CH_SPACE     = 8'h20;
	localparam logic [7:0] CH_TAB       = 8'h09;
	localparam logic [7:0] CH_NEWLINE   = 8'h0A;
	localparam logic [7:0] CH_BACKSPACE = 8'h08;

	// Attribute after reset: white on black.
	localparam logic [7:0] ATTR_RESET = 8'h0F;

	// Controller states.
	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_READ,
		ST_BLANK
	} tcw_state_t;

	// Cursor unit status toward the controller.
	typedef struct packed {
		logic               wrote;
		logic               scrolled;
		logic [FIELD_W-1:0] widx;
		logic [FIELD_W-1:0] next_pos;
		logic [FIELD_W-1:0] next_hw;
		logic [FIELD_W-1:0] pos;
		logic [FIELD_W-1:0] hw;
	} cursor_info_t;

endpackage

// ===== src/tcw_screen_ram.sv =====
// Screen cell memory: one write port, one read port with registered data.
// No package dependencies.
module tcw_screen_ram #(
	parameter int DEPTH = 2000,
	parameter int AW    = 11
) (
	input  logic          clk,
	input  logic          wr_en,
	input  logic [AW-1:0] wr_addr,
	input  logic [15:0]   wr_data,
	input  logic          rd_en,
	input  logic [AW-1:0] rd_addr,
	output logic [15:0]   rd_data
);

	logic [15:0] mem [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// Read port with registered data.
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

// ===== src/tcw_cursor.sv =====
// Working and visible cursor registers with the per-character cursor update.
// Depends on tcw_pkg for the character codes and the status struct.
module tcw_cursor #(
	parameter int COLUMNS  = tcw_pkg::COLUMNS_DEF,
	parameter int ROWS     = tcw_pkg::ROWS_DEF,
	parameter int TAB_STOP = tcw_pkg::TAB_STOP_DEF,
	parameter int AW       = $clog2(COLUMNS * ROWS)
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  step,
	input  logic [7:0]            character,
	input  logic                  end_of_write,
	output logic [AW-1:0]         wr_pos,
	output tcw_pkg::cursor_info_t info
);

	import tcw_pkg::*;

	localparam int CELLS    = COLUMNS * ROWS;
	localparam int CW       = AW + 1;
	localparam int COLW     = $clog2(COLUMNS);
	localparam int PW       = (TAB_STOP > 1) ? $clog2(TAB_STOP) : 1;
	// Phase shift when the cursor drops one row, kept non-negative.
	localparam int SCR_PH   = TAB_STOP - (COLUMNS % TAB_STOP);
	localparam int CLAMP_PH = (CELLS - COLUMNS) % TAB_STOP;
	// Scaled reciprocals of the row width and the tab spacing.
	localparam int RSH      = 17;
	localparam int REC_COL  = (1 << RSH) / COLUMNS + 1;
	localparam int REC_TAB  = (1 << RSH) / TAB_STOP + 1;

	// Remainder of a small value by a constant: the quotient comes from a scaled
	// reciprocal and is exact for every value below 512.
	function automatic logic [8:0] mod_small(input logic [8:0] v, input logic [8:0] m,
			input logic [17:0] rec);
		logic [26:0] prod;
		logic [17:0] qm;
		prod = 27'(v) * 27'(rec);
		qm   = 18'(prod >> RSH) * 18'(m);
		return v - qm[8:0];
	endfunction

	logic [AW-1:0]   cur_q;
	logic [AW-1:0]   vis_q;
	logic [COLW-1:0] col_q;
	logic [PW-1:0]   ph_q;

	logic [CW-1:0]   c1;
	logic [CW-1:0]   c2;
	logic [COLW-1:0] col1;
	logic [COLW-1:0] col2;
	logic [PW-1:0]   ph1;
	logic [PW-1:0]   ph2;
	logic [8:0]      adv;
	logic [8:0]      ph_sum;
	logic            wrote;
	logic            scr;
	logic [AW-1:0]   c_next;

	// Cursor movement for one character, then the scroll correction.
	always_comb begin
		c1     = {1'b0, cur_q};
		col1   = col_q;
		ph1    = ph_q;
		adv    = '0;
		wrote  = 1'b0;
		ph_sum = '0;
		case (character)
			CH_TAB: begin
				adv  = 9'(TAB_STOP) - 9'(ph_q);
				c1   = {1'b0, cur_q} + CW'(adv);
				col1 = COLW'(mod_small(9'(col_q) + adv, 9'(COLUMNS), 18'(REC_COL)));
				ph1  = '0;
			end
			CH_NEWLINE: begin
				adv  = 9'(COLUMNS) - 9'(col_q);
				c1   = {1'b0, cur_q} + CW'(adv);
				col1 = '0;
				ph1  = PW'(mod_small(9'(ph_q) + adv, 9'(TAB_STOP), 18'(REC_TAB)));
			end
			CH_BACKSPACE: begin
				c1 = {1'b0, cur_q};
			end
			default: begin
				// Space advances without a store; any other code is stored.
				wrote = (character != CH_SPACE);
				c1    = {1'b0, cur_q} + CW'(1);
				col1  = (col_q == COLW'(COLUMNS - 1)) ? '0 : col_q + COLW'(1);
				ph1   = (ph_q == PW'(TAB_STOP - 1)) ? '0 : ph_q + PW'(1);
			end
		endcase

		c2   = c1;
		col2 = col1;
		ph2  = ph1;
		scr  = 1'b0;
		if (c1 >= CW'(CELLS)) begin
			scr    = 1'b1;
			c2     = c1 - CW'(COLUMNS);
			ph_sum = 9'(ph1) + 9'(SCR_PH);
			if (ph_sum >= 9'(TAB_STOP)) begin
				ph_sum = ph_sum - 9'(TAB_STOP);
			end
			ph2 = PW'(ph_sum);
			// A long tab can still be past the end: park at the last row start.
			if (c2 >= CW'(CELLS)) begin
				c2   = CW'(CELLS - COLUMNS);
				col2 = '0;
				ph2  = PW'(CLAMP_PH);
			end
		end
		c_next = AW'(c2);
	end

	// Cursor registers advance on every accepted write item.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_q <= '0;
			vis_q <= '0;
			col_q <= '0;
			ph_q  <= '0;
		end else if (step) begin
			cur_q <= c_next;
			col_q <= col2;
			ph_q  <= ph2;
			if (end_of_write) begin
				vis_q <= c_next;
			end
		end
	end

	assign wr_pos        = cur_q;
	assign info.wrote    = wrote;
	assign info.scrolled = scr;
	assign info.widx     = wrote ? FIELD_W'(cur_q) : '0;
	assign info.next_pos = FIELD_W'(c_next);
	assign info.next_hw  = end_of_write ? FIELD_W'(c_next) : FIELD_W'(vis_q);
	assign info.pos      = FIELD_W'(cur_q);
	assign info.hw       = FIELD_W'(vis_q);

endmodule

// ===== src/text_console_writer.sv =====
// Text console writer top level: controller, row-rotated screen memory and cursor unit.
// Depends on tcw_pkg, tcw_screen_ram and tcw_cursor.
//
// A write beat that moves the cursor or stores one cell is handled in ST_IDLE; a read beat
// waits in ST_READ for the registered read port of the screen memory. A character that
// pushes the cursor off the end scrolls by rotating the row base and then writes blanks
// over the COLUMNS cells of the new last row (80 at default size) in ST_BLANK.
// After reset the memory is cleared one cell per cycle, all COLUMNS*ROWS cells
// (2000 at default size), with s_tready low; the configuration port is live
// throughout. A new beat is taken only while the output register is empty or hands
// its result on in the same cycle, so a stalled result stream holds off the input.
module text_console_writer #(
	parameter int COLUMNS  = tcw_pkg::COLUMNS_DEF,
	parameter int ROWS     = tcw_pkg::ROWS_DEF,
	parameter int TAB_STOP = tcw_pkg::TAB_STOP_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	// Attribute register write
	input  logic        cfg_we,
	input  logic [7:0]  cfg_wdata,
	// Input stream
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,   // character[7:0], cell_index[18:8], zero fill
	input  logic        s_tuser,   // func: 0 write character, 1 read cell
	input  logic        s_tlast,   // end_of_write
	// Result stream
	output logic        m_tvalid,
	input  logic        m_tready,
	// cursor_position[10:0], hardware_cursor[21:11], cell_written[22],
	// written_index[33:23], scrolled[34], read_char[42:35], read_attribute[50:43]
	output logic [55:0] m_tdata
);

	import tcw_pkg::*;

	localparam int CELLS = COLUMNS * ROWS;
	localparam int AW    = $clog2(CELLS);
	localparam int AW1   = AW + 1;

	// Logical cell to physical address under the current row rotation.
	function automatic logic [AW-1:0] to_phys(input logic [AW-1:0] lg, input logic [AW-1:0] b);
		logic [AW:0] s;
		s = {1'b0, lg} + {1'b0, b};
		if (s >= AW1'(CELLS)) begin
			s = s - AW1'(CELLS);
		end
		return AW'(s);
	endfunction

	tcw_state_t   state_q;
	tcw_state_t   state_d;
	logic [7:0]   attr_q;
	logic [AW-1:0] base_q;
	logic [AW-1:0] sweep_addr_q;
	logic [AW-1:0] sweep_last_q;
	logic         rd_ok_q;
	logic         m_tvalid_q;
	logic [55:0]  m_tdata_q;

	logic         out_free;
	logic         acc;
	logic         acc_wr;
	logic         acc_rd;
	logic         ram_we;
	logic [AW-1:0] ram_waddr;
	logic [15:0]  ram_wdata;
	logic [AW-1:0] ram_raddr;
	logic [15:0]  ram_rdata;
	logic [15:0]  rd_cell;
	logic         idx_in_range;
	logic [AW-1:0] wr_pos;
	logic [7:0]   character;
	logic [FIELD_W-1:0] cell_index;
	cursor_info_t info;
	logic [55:0]  wr_beat;
	logic [55:0]  rd_beat;

	assign character    = s_tdata[7:0];
	assign cell_index   = s_tdata[18:8];
	assign idx_in_range = {5'd0, cell_index} < 16'(CELLS);

	tcw_screen_ram #(
		.DEPTH (CELLS),
		.AW    (AW)
	) u_ram (
		.clk     (clk),
		.wr_en   (ram_we),
		.wr_addr (ram_waddr),
		.wr_data (ram_wdata),
		.rd_en   (acc_rd),
		.rd_addr (ram_raddr),
		.rd_data (ram_rdata)
	);

	tcw_cursor #(
		.COLUMNS  (COLUMNS),
		.ROWS     (ROWS),
		.TAB_STOP (TAB_STOP),
		.AW       (AW)
	) u_cursor (
		.clk          (clk),
		.arst_n       (arst_n),
		.step         (acc_wr),
		.character    (character),
		.end_of_write (s_tlast),
		.wr_pos       (wr_pos),
		.info         (info)
	);

	// Result beats for both item kinds.
	assign rd_cell = rd_ok_q ? ram_rdata : 16'h0000;
	assign wr_beat = {5'd0, 8'd0, 8'd0, info.scrolled, info.widx, info.wrote,
		info.next_hw, info.next_pos};
	assign rd_beat = {5'd0, rd_cell[15:8], rd_cell[7:0], 1'b0, FIELD_W'(0), 1'b0,
		info.hw, info.pos};

	// Next state, handshake and memory port control.
	always_comb begin
		out_free  = !m_tvalid_q || m_tready;
		s_tready  = (state_q == ST_IDLE) && out_free;
		acc       = s_tvalid && s_tready;
		acc_wr    = acc && !s_tuser;
		acc_rd    = acc && s_tuser;
		ram_raddr = to_phys(AW'(cell_index), base_q);
		ram_we    = 1'b0;
		ram_waddr = sweep_addr_q;
		ram_wdata = 16'h0000;
		state_d   = state_q;
		case (state_q)
			ST_CLEAR: begin
				ram_we = 1'b1;
				if (sweep_addr_q == AW'(CELLS - 1)) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				ram_we    = acc_wr && info.wrote;
				ram_waddr = to_phys(wr_pos, base_q);
				ram_wdata = {attr_q, character};
				if (acc_rd) begin
					state_d = ST_READ;
				end else if (acc_wr && info.scrolled) begin
					state_d = ST_BLANK;
				end
			end
			ST_READ: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			ST_BLANK: begin
				ram_we    = 1'b1;
				ram_wdata = {attr_q, CH_SPACE};
				if (sweep_addr_q == sweep_last_q) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	// Attribute register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			attr_q <= ATTR_RESET;
		end else if (cfg_we) begin
			attr_q <= cfg_wdata;
		end
	end

	// Row rotation and blanking sweep. A scroll frees the old top row as the new last row.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q       <= '0;
			sweep_addr_q <= '0;
			sweep_last_q <= '0;
		end else begin
			if (state_q == ST_CLEAR || state_q == ST_BLANK) begin
				sweep_addr_q <= sweep_addr_q + AW'(1);
			end else if (acc_wr && info.scrolled) begin
				sweep_addr_q <= base_q;
				sweep_last_q <= base_q + AW'(COLUMNS - 1);
				base_q       <= (base_q == AW'(CELLS - COLUMNS)) ? '0 : base_q + AW'(COLUMNS);
			end
		end
	end

	// Range flag for the pending read.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_ok_q <= 1'b0;
		end else if (acc_rd) begin
			rd_ok_q <= idx_in_range;
		end
	end

	// Output register: valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (acc_wr || (state_q == ST_READ && out_free)) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	// Output register: payload.
	always_ff @(posedge clk) begin
		if (acc_wr) begin
			m_tdata_q <= wr_beat;
		end else if (state_q == ST_READ && out_free) begin
			m_tdata_q <= rd_beat;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

endmodule
